@@ rtl/scalar_kalman_angle_filter_core_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef SCALAR_KALMAN_ANGLE_FILTER_CORE_MACROS_SVH
`define SCALAR_KALMAN_ANGLE_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define SKAF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skaf: same-cycle check failed");

// next-cycle implication
`define SKAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skaf: next-cycle check failed");

`endif

@@ rtl/skaf_pkg.sv @@
package skaf_pkg;

   localparam int MUL_W       = 33;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DIV_W       = 49;
   localparam int QUO_W       = 17;
   localparam int STEP_Q_W    = 29;
   localparam int RECIP_SHIFT = 36;

   localparam logic [4:0] DIV_STEPS = 5'd17;

   localparam logic [DIV_W-1:0] US_PER_S  = DIV_W'(1000000);
   localparam logic [DIV_W-1:0] US_HALF   = DIV_W'(500000);
   // floor(2^52 / 10^6); x / 10^6 is ((x >> 16) * RECIP_US) >> 36, low by at most one
   localparam logic [MUL_W-1:0] RECIP_US  = 33'd4503599627;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_INITIAL_ANGLE      = 2'd0;
   localparam csr_index_type CSR_INITIAL_COVARIANCE = 2'd1;
   localparam csr_index_type CSR_PROCESS_NOISE      = 2'd2;
   localparam csr_index_type CSR_MEASUREMENT_NOISE  = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_RATE,
      ST_RECIP_RATE,
      ST_BACK_RATE,
      ST_FIX_RATE,
      ST_MUL_NOISE,
      ST_RECIP_NOISE,
      ST_BACK_NOISE,
      ST_FIX_NOISE,
      ST_MUL_GROW,
      ST_GROW,
      ST_R2,
      ST_DIV_GAIN,
      ST_WAIT_GAIN,
      ST_MUL_CORR,
      ST_CORR,
      ST_VAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/skaf_mul.sv @@
module skaf_mul
   import skaf_pkg::*;
(
   input  logic              clock,
   input  logic [MUL_W-1:0]  mul_a,
   input  logic [MUL_W-1:0]  mul_b,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ rtl/skaf_div.sv @@
module skaf_div
   import skaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   // restoring divider, one quotient bit per cycle
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [4:0]       count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, low_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in   = rem_ff;
      low_in   = low_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         den_in   = div_req.divisor;
         busy_in  = 1'b1;
         rem_in   = {{QUO_W{1'b0}}, div_req.dividend[DIV_W-1:QUO_W]};
         low_in   = div_req.dividend[QUO_W-1:0];
         count_in = DIV_STEPS;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         low_in   = {low_ff[QUO_W-2:0], ge};
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 5'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = low_ff;

endmodule

@@ rtl/scalar_kalman_angle_filter_core.sv @@
// One-dimensional Kalman filter for a tilt angle, Q16.16 fixed point. Each request word
// carries a step in microseconds, a measured angle and a measured rate, and gives one
// response word with the saturated angle estimate, the Q0.16 gain and the variance. A
// restart word reloads angle and variance from the initial registers and answers with gain
// zero once the response register is free, then takes the next request. One 33x33
// registered multiplier is shared by all products. Each divide by one million is a
// reciprocal multiply, a back-multiply and one correction, following its rate or noise
// product; the gain comes from a serial divider yielding one quotient bit per cycle over
// 17 steps, skipped when the gain denominator is zero. req_stall is high while a word is
// in work; a finished response waits in its own register, so the next request is taken
// while the response is still stalled, and the following finished word holds until that
// register frees. Initial angle and covariance writes affect the state only at restart;
// the noise registers are read by each filter word as it runs.
`include "scalar_kalman_angle_filter_core_macros.svh"

module scalar_kalman_angle_filter_core
   import skaf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_write_data,

   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_restart,
   input  logic [15:0]   req_step_us,
   input  logic [31:0]   req_measured_angle,
   input  logic [31:0]   req_measured_rate,

   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [31:0]   rsp_angle_estimate,
   output logic [15:0]   rsp_gain,
   output logic [31:0]   rsp_variance
);

   function automatic logic [31:0] sat32(input logic [34:0] x);
      logic [31:0] y;
      if (x[34:31] == 4'b0000 || x[34:31] == 4'b1111) begin
         y = x[31:0];
      end else if (x[34]) begin
         y = 32'h8000_0000;
      end else begin
         y = 32'h7fff_ffff;
      end
      return y;
   endfunction

   state_type state_ff, state_in;

   logic [31:0] init_angle_ff, init_cov_ff, proc_noise_ff, meas_noise_ff;

   logic [15:0] step_us_ff;
   logic [31:0] meas_angle_ff, meas_rate_ff;

   logic [31:0] angle_ff, var_ff, ap_ff, pp_ff;
   logic [15:0] gain_ff;
   logic [STEP_Q_W-1:0] s_ff;
   logic [47:0] r2_ff;
   logic        corr_neg_ff;

   logic [DIV_W-1:0]    us_num_ff;
   logic [STEP_Q_W-1:0] us_quo_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_angle_ff, rsp_var_ff;
   logic [15:0] rsp_gain_ff;

   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [PROD_W-1:0] prod_half;
   logic [31:0]       rate_mag;
   logic [34:0]       delta_sum;
   logic [32:0]       diff, diff_mag;
   logic [32:0]       corr;
   logic [34:0]       corr_sum;
   logic [42:0]       grow;
   logic [43:0]       pp_sum;
   logic [31:0]       pp_sat;
   logic [DIV_W-1:0]  den, gain_dividend, step_dividend;
   logic [DIV_W-1:0]  us_rem;
   logic [STEP_Q_W-1:0] recip_quo, us_quo;
   logic [16:0]       one_minus_gain;
   logic              slot_free;

   skaf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   skaf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign prod_half = prod + PROD_W'(32768);
   assign rate_mag  = meas_rate_ff[31] ? 32'(-meas_rate_ff) : meas_rate_ff;
   assign recip_quo = prod[RECIP_SHIFT +: STEP_Q_W];
   assign us_rem    = us_num_ff - prod[DIV_W-1:0];
   assign us_quo    = us_quo_ff + STEP_Q_W'(us_rem >= US_PER_S);
   assign delta_sum = meas_rate_ff[31]
                    ? {{3{angle_ff[31]}}, angle_ff} - {6'b0, us_quo}
                    : {{3{angle_ff[31]}}, angle_ff} + {6'b0, us_quo};
   assign diff      = {meas_angle_ff[31], meas_angle_ff} - {ap_ff[31], ap_ff};
   assign diff_mag  = diff[32] ? 33'(-diff) : diff;
   assign corr      = prod_half[48:16];
   assign corr_sum  = corr_neg_ff
                    ? {{3{ap_ff[31]}}, ap_ff} - {2'b0, corr}
                    : {{3{ap_ff[31]}}, ap_ff} + {2'b0, corr};
   assign grow      = prod_half[58:16];
   assign pp_sum    = {12'b0, var_ff} + {1'b0, grow};
   assign pp_sat    = (pp_sum[43:32] != 12'b0) ? 32'hffff_ffff : pp_sum[31:0];
   assign den       = {17'b0, pp_ff} + {1'b0, r2_ff};
   assign gain_dividend = {1'b0, pp_ff, 16'b0} + {1'b0, den[DIV_W-1:1]};
   assign step_dividend = prod[DIV_W-1:0] + US_HALF;
   assign one_minus_gain = 17'h1_0000 - {1'b0, gain_ff};
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_restart ? ST_DONE : ST_MUL_RATE;
            end
         end
         ST_MUL_RATE:    state_in = ST_RECIP_RATE;
         ST_RECIP_RATE:  state_in = ST_BACK_RATE;
         ST_BACK_RATE:   state_in = ST_FIX_RATE;
         ST_FIX_RATE:    state_in = ST_MUL_NOISE;
         ST_MUL_NOISE:   state_in = ST_RECIP_NOISE;
         ST_RECIP_NOISE: state_in = ST_BACK_NOISE;
         ST_BACK_NOISE:  state_in = ST_FIX_NOISE;
         ST_FIX_NOISE:   state_in = ST_MUL_GROW;
         ST_MUL_GROW:    state_in = ST_GROW;
         ST_GROW:        state_in = ST_R2;
         ST_R2:          state_in = ST_DIV_GAIN;
         ST_DIV_GAIN:    state_in = (den == '0) ? ST_MUL_CORR : ST_WAIT_GAIN;
         ST_WAIT_GAIN:   if (div_rsp.done) state_in = ST_MUL_CORR;
         ST_MUL_CORR:    state_in = ST_CORR;
         ST_CORR:        state_in = ST_VAR;
         ST_VAR:         state_in = ST_DONE;
         ST_DONE:        if (slot_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // unit controls
   always_comb begin
      req_stall        = (state_ff != ST_IDLE);
      mul_a            = '0;
      mul_b            = '0;
      div_req.start    = 1'b0;
      div_req.dividend = gain_dividend;
      div_req.divisor  = den;
      case (state_ff)
         ST_MUL_RATE: begin
            mul_a = {1'b0, rate_mag};
            mul_b = {17'b0, step_us_ff};
         end
         ST_RECIP_RATE, ST_RECIP_NOISE: begin
            mul_a = step_dividend[DIV_W-1:16];
            mul_b = RECIP_US;
         end
         ST_BACK_RATE, ST_BACK_NOISE: begin
            mul_a = {4'b0, recip_quo};
            mul_b = US_PER_S[MUL_W-1:0];
         end
         ST_MUL_NOISE: begin
            mul_a = {1'b0, proc_noise_ff};
            mul_b = {17'b0, step_us_ff};
         end
         ST_MUL_GROW: begin
            mul_a = {4'b0, s_ff};
            mul_b = {4'b0, s_ff};
         end
         ST_GROW: begin
            mul_a = {1'b0, meas_noise_ff};
            mul_b = {1'b0, meas_noise_ff};
         end
         ST_DIV_GAIN: begin
            div_req.start = (den != '0);
         end
         ST_MUL_CORR: begin
            mul_a = diff_mag;
            mul_b = {17'b0, gain_ff};
         end
         ST_CORR: begin
            mul_a = {1'b0, pp_ff};
            mul_b = {16'b0, one_minus_gain};
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         init_angle_ff <= 32'd0;
         init_cov_ff   <= 32'd0;
         proc_noise_ff <= 32'd262144;
         meas_noise_ff <= 32'd196608;
         angle_ff      <= 32'd0;
         var_ff        <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_INITIAL_ANGLE:      init_angle_ff <= csr_write_data;
               CSR_INITIAL_COVARIANCE: init_cov_ff   <= csr_write_data;
               CSR_PROCESS_NOISE:      proc_noise_ff <= csr_write_data;
               CSR_MEASUREMENT_NOISE:  meas_noise_ff <= csr_write_data;
               default:                init_angle_ff <= init_angle_ff;
            endcase
         end
         if (state_ff == ST_IDLE && req_valid && req_restart) begin
            angle_ff <= init_angle_ff;
            var_ff   <= init_cov_ff;
         end
         if (state_ff == ST_CORR) begin
            angle_ff <= sat32(corr_sum);
         end
         if (state_ff == ST_VAR) begin
            var_ff <= prod_half[47:16];
         end
         if (state_ff == ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         step_us_ff    <= req_step_us;
         meas_angle_ff <= req_measured_angle;
         meas_rate_ff  <= req_measured_rate;
         gain_ff       <= 16'd0;
      end
      if (state_ff == ST_RECIP_RATE || state_ff == ST_RECIP_NOISE) begin
         us_num_ff <= step_dividend;
      end
      if (state_ff == ST_BACK_RATE || state_ff == ST_BACK_NOISE) begin
         us_quo_ff <= recip_quo;
      end
      if (state_ff == ST_FIX_RATE) begin
         ap_ff <= sat32(delta_sum);
      end
      if (state_ff == ST_FIX_NOISE) begin
         s_ff <= us_quo;
      end
      if (state_ff == ST_GROW) begin
         pp_ff <= pp_sat;
      end
      if (state_ff == ST_R2) begin
         r2_ff <= prod_half[63:16];
      end
      if (state_ff == ST_WAIT_GAIN && div_rsp.done) begin
         gain_ff <= div_rsp.quotient[16] ? 16'hffff : div_rsp.quotient[15:0];
      end
      if (state_ff == ST_MUL_CORR) begin
         corr_neg_ff <= diff[32];
      end
      if (state_ff == ST_DONE && slot_free) begin
         rsp_angle_ff <= angle_ff;
         rsp_var_ff   <= var_ff;
         rsp_gain_ff  <= gain_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_angle_estimate = rsp_angle_ff;
   assign rsp_gain           = rsp_gain_ff;
   assign rsp_variance       = rsp_var_ff;

   `SKAF_ASSERT_SAME(a_div_done_in_wait, clock, reset, div_rsp.done, (state_ff == ST_WAIT_GAIN))
   `SKAF_ASSERT_SAME(a_div_start_when_free, clock, reset, div_req.start, !div_rsp.busy)
   `SKAF_ASSERT_NEXT(a_done_publishes, clock, reset, (state_ff == ST_DONE) && slot_free, rsp_valid && (state_ff == ST_IDLE))

endmodule

@@ test/scalar_kalman_angle_filter_core_test.sv @@
module scalar_kalman_angle_filter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import skaf_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES = 100;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_INITIAL_ANGLE;
   logic [31:0]   csr_write_data = '0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_restart = 1'b0;
   logic [15:0]   req_step_us = '0;
   logic [31:0]   req_measured_angle = '0;
   logic [31:0]   req_measured_rate = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [31:0]   rsp_angle_estimate;
   logic [15:0]   rsp_gain;
   logic [31:0]   rsp_variance;

   int hold_len = 0;
   bit quiet = 1'b0;
   int idle_cycles = 0;
   int settings_used = 0;

   typedef struct packed {
      logic [31:0] angle;
      logic [15:0] gain;
      logic [31:0] variance;
   } filter_estimate_type;

   class angle_filter_scoreboard;
      logic signed [31:0] init_angle;
      logic [31:0]        init_cov;
      logic [31:0]        proc_noise;
      logic [31:0]        meas_noise;
      logic signed [31:0] angle_est;
      logic [31:0]        var_est;
      filter_estimate_type expected_estimates[$];
      int errors, words_in, words_out, restarts, zero_den, gain_clamped, angle_sat, var_sat;

      function new();
         init_angle = '0;
         init_cov = '0;
         proc_noise = 32'd262144;
         meas_noise = 32'd196608;
         angle_est = init_angle;
         var_est = init_cov;
         errors = 0;
         words_in = 0;
         words_out = 0;
         restarts = 0;
         zero_den = 0;
         gain_clamped = 0;
         angle_sat = 0;
         var_sat = 0;
      endfunction

      function longint round_div(longint num, longint den);
         longint mag;
         mag = (num < 0) ? -num : num;
         mag = (mag + den / 2) / den;
         return (num < 0) ? -mag : mag;
      endfunction

      function longint clamp_s32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_INITIAL_ANGLE: init_angle = value;
            CSR_INITIAL_COVARIANCE: init_cov = value;
            CSR_PROCESS_NOISE: proc_noise = value;
            CSR_MEASUREMENT_NOISE: meas_noise = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_estimates.size();
      endfunction

      function void note_request(logic restart, logic [15:0] step_us,
                                 logic signed [31:0] meas_angle,
                                 logic signed [31:0] meas_rate);
         longint meas, rate, dt, kl, raw, pred_angle, corr;
         logic [63:0] dt_u, noise_step, grow, pred_var, r2, den, g, corrected;
         logic [15:0] k;
         filter_estimate_type e;
         k = '0;
         words_in++;
         if (restart) begin
            restarts++;
            angle_est = init_angle;
            var_est = init_cov;
         end else begin
            meas = meas_angle;
            rate = meas_rate;
            dt = step_us;
            dt_u = step_us;
            raw = longint'(angle_est) + round_div(rate * dt, 1000000);
            pred_angle = clamp_s32(raw);
            if (pred_angle != raw) angle_sat++;
            noise_step = (64'(proc_noise) * dt_u + 64'd500000) / 64'd1000000;
            grow = (noise_step * noise_step + 64'd32768) >> 16;
            pred_var = 64'(var_est) + grow;
            if (pred_var > 64'hFFFF_FFFF) begin
               pred_var = 64'hFFFF_FFFF;
               var_sat++;
            end
            r2 = (64'(meas_noise) * 64'(meas_noise) + 64'd32768) >> 16;
            den = pred_var + r2;
            if (den == 0) begin
               zero_den++;
            end else begin
               g = (pred_var * 64'd65536 + den / 2) / den;
               if (g > 64'd65535) begin
                  k = 16'hFFFF;
                  gain_clamped++;
               end else begin
                  k = g[15:0];
               end
            end
            kl = k;
            corr = round_div((meas - pred_angle) * kl, 65536);
            raw = pred_angle + corr;
            if (clamp_s32(raw) != raw) angle_sat++;
            angle_est = 32'(clamp_s32(raw));
            corrected = (pred_var * (64'd65536 - 64'(k)) + 64'd32768) >> 16;
            if (corrected > 64'hFFFF_FFFF) corrected = 64'hFFFF_FFFF;
            var_est = corrected[31:0];
         end
         e.angle = angle_est;
         e.gain = k;
         e.variance = var_est;
         expected_estimates.push_back(e);
      endfunction

      function void check_response(logic [31:0] angle, logic [15:0] gain,
                                   logic [31:0] variance);
         filter_estimate_type e;
         words_out++;
         if (expected_estimates.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
            return;
         end
         e = expected_estimates.pop_front();
         if (angle !== e.angle) begin
            $error("angle_estimate: expected %0d, got %0d", $signed(e.angle), $signed(angle));
            errors++;
         end
         if (gain !== e.gain) begin
            $error("gain: expected %0d, got %0d", e.gain, gain);
            errors++;
         end
         if (variance !== e.variance) begin
            $error("variance: expected %0d, got %0d", e.variance, variance);
            errors++;
         end
      endfunction
   endclass

   angle_filter_scoreboard sb = new();

   scalar_kalman_angle_filter_core uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_restart        (req_restart),
      .req_step_us        (req_step_us),
      .req_measured_angle (req_measured_angle),
      .req_measured_rate  (req_measured_rate),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_angle_estimate (rsp_angle_estimate),
      .rsp_gain           (rsp_gain),
      .rsp_variance       (rsp_variance)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side stall, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_len > 0) begin
         rsp_stall <= 1'b1;
         hold_len--;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 30);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_angle_estimate, rsp_gain, rsp_variance);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_word(input logic restart, input logic [15:0] step_us,
                            input logic [31:0] meas_angle, input logic [31:0] meas_rate);
      int gap;
      if (!quiet && $urandom_range(99) < 30) begin
         gap = $urandom_range(1, 100);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      req_step_us <= step_us;
      req_measured_angle <= meas_angle;
      req_measured_rate <= meas_rate;
      do @(posedge clock); while (req_stall);
      sb.note_request(restart, step_us, meas_angle, meas_rate);
   endtask

   task automatic send_random_word();
      logic        restart;
      logic [15:0] step_us;
      logic [31:0] meas_angle, meas_rate;
      restart = ($urandom_range(99) < 4);
      if ($urandom_range(99) < 75) begin
         // plausible IMU sample: +-90 deg, +-500 deg/s, 0.5..20 ms
         step_us = 16'($urandom_range(500, 20000));
         meas_angle = $urandom_range(0, 11796480) - 32'd5898240;
         meas_rate = $urandom_range(0, 65536000) - 32'd32768000;
      end else begin
         step_us = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
         meas_angle = $urandom;
         meas_rate = $urandom;
      end
      send_word(restart, step_us, meas_angle, meas_rate);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_filter(input logic [31:0] init_angle, input logic [31:0] init_cov,
                                 input logic [31:0] proc_noise, input logic [31:0] meas_noise);
      logic [31:0] values[4];
      values = '{init_angle, init_cov, proc_noise, meas_noise};
      for (int idx = 0; idx < 4; idx++) begin
         csr_write_enable <= 1'b1;
         csr_index <= csr_index_type'(idx);
         csr_write_data <= values[idx];
         @(posedge clock);
         sb.write_reg(csr_index_type'(idx), values[idx]);
      end
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      send_word(1'b0, 16'd0, 32'h0, 32'h0);
      send_word(1'b0, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(1'b0, 16'hFFFF, 32'h8000_0000, 32'h8000_0000);
      send_word(1'b0, 16'd1000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      settle_block();

      // no measurement noise: gain clamps to one, angle and variance saturate
      program_filter(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_word(1'b1, 16'd0, 32'h0, 32'h0);
      send_word(1'b0, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(1'b0, 16'hFFFF, 32'h8000_0000, 32'h8000_0000);
      send_word(1'b0, 16'd1, 32'h0, 32'h0);
      settle_block();

      // zero denominator
      program_filter(32'h8000_0000, 32'h0, 32'h0, 32'h0);
      send_word(1'b1, 16'd0, 32'h0, 32'h0);
      send_word(1'b0, 16'd0, 32'h1234_5678, 32'h0);
      send_word(1'b0, 16'hFFFF, 32'h8000_0000, 32'h8000_0000);
      settle_block();

      // tiny measurement noise, gain rounds up to one
      program_filter(32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0100);
      send_word(1'b1, 16'd0, 32'h0, 32'h0);
      send_word(1'b0, 16'd10000, 32'h005A_0000, 32'h0);
      send_word(1'b0, 16'd20000, 32'hFFA6_0000, 32'h0064_0000);
      settle_block();

      // huge measurement noise
      program_filter(32'hFFFF_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(1'b1, 16'd0, 32'h0, 32'h0);
      send_word(1'b0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(1'b0, 16'd5000, 32'h0010_0000, 32'h0);

      for (int phase = 0; phase < 6; phase++) begin
         settle_block();
         case (phase)
            0: program_filter(32'h0, 32'h0, 32'd262144, 32'd196608);
            1, 4: program_filter($urandom_range(0, 11796480) - 32'd5898240,
                                 $urandom_range(0, 655360), $urandom_range(0, 655360),
                                 $urandom_range(0, 327680));
            2: program_filter($urandom, $urandom, $urandom, $urandom);
            3: program_filter($urandom_range(0, 11796480) - 32'd5898240, 32'h0,
                              $urandom_range(0, 655360), 32'h0);
            default: program_filter($urandom, $urandom, $urandom_range(0, 655360),
                                    $urandom_range(0, 255));
         endcase
         quiet = (phase == 4);
         for (int n = 0; n < 255; n++) begin
            if (phase == 2 && n == 100) hold_len = HOLD_CYCLES;
            send_random_word();
         end
      end
      quiet = 1'b0;
      settle_block();

      $display("summary: %0d words in, %0d out, %0d restarts, %0d register settings",
               sb.words_in, sb.words_out, sb.restarts, settings_used);
      $display("summary: %0d zero denominators, %0d clamped gains, %0d angle and %0d %s",
               sb.zero_den, sb.gain_clamped, sb.angle_sat, sb.var_sat,
               "variance saturations");
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
